[rtl/dtsg_pkg.sv]
// Shared constants, register indexes and the sine table helper for the
// dual-tone sample generator. No dependencies.
`default_nettype none

package dtsg_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int STEP_W      = 32;
    localparam int AMP_W       = 15;
    localparam int COUNT_W     = 32;
    localparam int SAMPLE_W    = 16;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP_A     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP_B     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_MODE        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DURATION_SAMPLES = 3'd4;

    localparam logic [STEP_W-1:0]  RST_PHASE_STEP_A = 32'd42852282;
    localparam logic [STEP_W-1:0]  RST_PHASE_STEP_B = 32'd34087043;
    localparam logic               RST_TONE_MODE    = 1'b0;
    localparam logic [AMP_W-1:0]   RST_AMPLITUDE    = 15'd16000;
    localparam logic [COUNT_W-1:0] RST_DURATION     = 32'd0;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Q2.30 quarter-wave sine via Taylor series, rounded to Q1.15 magnitude.
    function automatic logic [SAMPLE_W-1:0] quarter_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] sum;
        logic [63:0] v;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (int n = 1; n <= 7; n++) begin
            term = (term * x2) >> 30;
            case (n)
                1: term = term / 64'd6;
                2: term = term / 64'd20;
                3: term = term / 64'd42;
                4: term = term / 64'd72;
                5: term = term / 64'd110;
                6: term = term / 64'd156;
                default: term = term / 64'd210;
            endcase
            if (n % 2 == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        sum = (pos > neg) ? pos - neg : 64'd0;
        if (sum > ONE_Q30) begin
            sum = ONE_Q30;
        end
        v = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/dual_tone_sample_generator_top.sv]
// Dual-tone DDS sample generator: phase accumulators, sine ROM, scaling.
// Depends on dtsg_pkg and dtsg_sine_rom.
//
//  Channel | Dir | Ports                         | Payload
//  s_      | in  | s_tvalid s_tready s_tdata     | tdata[0] restart
//  m_      | out | m_tvalid m_tready m_tdata ... | tdata[15:0] sample, tuser[0] done_res
//  cfg_    | in  | cfg_wr_en cfg_index cfg_wdata | register write, no read-back
//
// One item per cycle sustained while m_tready holds; the result is registered
// through ROM read, multiply and scale/output register. Phase update is one add per item.
// A stall on m_ backs up through the pipeline; s_tready drops only when all
// stages hold items. Synchronous reset clears valids, phases, count and
// restores register defaults.
`default_nettype none

module dual_tone_sample_generator_top #(
    parameter int TABLE_DEPTH = 256,
    parameter int PHASE_BITS  = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [dtsg_pkg::S_TDATA_W-1:0]      s_tdata,   // [0] restart
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [dtsg_pkg::M_TDATA_W-1:0]           m_tdata,   // [15:0] sample
    output logic [0:0]                               m_tuser,   // [0] done_res
    input  wire logic                                cfg_wr_en,
    input  wire logic [dtsg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [dtsg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int SCALE_W = PHASE_BITS + IDX_W;

    // configuration
    logic [dtsg_pkg::STEP_W-1:0]  phase_step_a_reg;
    logic [dtsg_pkg::STEP_W-1:0]  phase_step_b_reg;
    logic                         tone_mode_reg;
    logic [dtsg_pkg::AMP_W-1:0]   amplitude_reg;
    logic [dtsg_pkg::COUNT_W-1:0] duration_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_a_reg <= dtsg_pkg::RST_PHASE_STEP_A;
            phase_step_b_reg <= dtsg_pkg::RST_PHASE_STEP_B;
            tone_mode_reg    <= dtsg_pkg::RST_TONE_MODE;
            amplitude_reg    <= dtsg_pkg::RST_AMPLITUDE;
            duration_reg     <= dtsg_pkg::RST_DURATION;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dtsg_pkg::REG_PHASE_STEP_A:     phase_step_a_reg <= cfg_wdata;
                dtsg_pkg::REG_PHASE_STEP_B:     phase_step_b_reg <= cfg_wdata;
                dtsg_pkg::REG_TONE_MODE:        tone_mode_reg    <= cfg_wdata[0];
                dtsg_pkg::REG_AMPLITUDE:        amplitude_reg    <= cfg_wdata[dtsg_pkg::AMP_W-1:0];
                dtsg_pkg::REG_DURATION_SAMPLES: duration_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic s1_valid_reg, s2_valid_reg, m_tvalid_reg;
    logic out_adv, s2_adv, s1_adv;

    assign out_adv  = !m_tvalid_reg || m_tready;
    assign s2_adv   = !s2_valid_reg || out_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign s_tready = s1_adv;

    logic accept;
    assign accept = s_tvalid && s_tready;

    // stage 0: phase accumulators and sample count
    logic [PHASE_BITS-1:0]        phase_a_reg, phase_b_reg, phase_a_next, phase_b_next;
    logic [dtsg_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [PHASE_BITS-1:0]        pa, pb;
    logic [dtsg_pkg::COUNT_W-1:0] cnt;
    logic                         restart, done0;
    logic [SCALE_W-1:0]           scaled_a, scaled_b;
    logic [IDX_W-1:0]             idx_a, idx_b;

    always_comb begin
        restart  = s_tdata[0];
        pa       = restart ? '0 : phase_a_reg;
        pb       = restart ? '0 : phase_b_reg;
        cnt      = restart ? '0 : count_reg;
        done0    = (duration_reg != '0) && (cnt >= duration_reg);
        scaled_a = {{IDX_W{1'b0}}, pa} * SCALE_W'(TABLE_DEPTH);
        scaled_b = {{IDX_W{1'b0}}, pb} * SCALE_W'(TABLE_DEPTH);
        idx_a    = scaled_a[PHASE_BITS +: IDX_W];
        idx_b    = scaled_b[PHASE_BITS +: IDX_W];
        if (done0) begin
            phase_a_next = pa;
            phase_b_next = pb;
            count_next   = cnt;
        end else begin
            phase_a_next = pa + phase_step_a_reg[PHASE_BITS-1:0];
            phase_b_next = pb + phase_step_b_reg[PHASE_BITS-1:0];
            count_next   = (cnt == '1) ? cnt : cnt + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_a_reg <= '0;
            phase_b_reg <= '0;
            count_reg   <= '0;
        end else if (accept) begin
            phase_a_reg <= phase_a_next;
            phase_b_reg <= phase_b_next;
            count_reg   <= count_next;
        end
    end

    // stage 1: ROM read
    logic signed [dtsg_pkg::SAMPLE_W-1:0] rom_a, rom_b;
    logic                                 s1_done_reg;

    dtsg_sine_rom #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rom (
        .aclk          (aclk),
        .rd_en         (s1_adv),
        .rd_addr_a     (idx_a),
        .rd_addr_b     (idx_b),
        .rd_data_a_reg (rom_a),
        .rd_data_b_reg (rom_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s1_done_reg <= done0;
        end
    end

    // stage 2: multiply
    logic signed [dtsg_pkg::SAMPLE_W:0]   operand;
    logic        [dtsg_pkg::AMP_W-1:0]    gain;
    logic signed [2*dtsg_pkg::SAMPLE_W:0] prod_next;
    logic signed [2*dtsg_pkg::SAMPLE_W-1:0] prod_reg;
    logic                                 s2_done_reg;

    always_comb begin
        if (tone_mode_reg) begin
            operand = {rom_a[dtsg_pkg::SAMPLE_W-1], rom_a} + {rom_b[dtsg_pkg::SAMPLE_W-1], rom_b};
            gain    = amplitude_reg >> 1;
        end else begin
            operand = {rom_a[dtsg_pkg::SAMPLE_W-1], rom_a};
            gain    = amplitude_reg;
        end
        prod_next = operand * signed'({1'b0, gain});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            prod_reg    <= prod_next[2*dtsg_pkg::SAMPLE_W-1:0];
            s2_done_reg <= s1_done_reg;
        end
    end

    // stage 3: divide by 2^15 toward zero, output register
    logic signed [2*dtsg_pkg::SAMPLE_W-1:0] biased;
    logic [dtsg_pkg::M_TDATA_W-1:0]         m_tdata_reg;
    logic                                   m_done_reg;

    assign biased = prod_reg + (prod_reg[2*dtsg_pkg::SAMPLE_W-1] ? 32'sd32767 : 32'sd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_adv) begin
            m_tvalid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            m_tdata_reg <= s2_done_reg ? '0 : biased[30:15];
            m_done_reg  <= s2_done_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_done_reg;

    // checks
    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("done item carries nonzero sample");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> s1_valid_reg && s2_valid_reg && m_tvalid_reg)
        else $error("input stalled with a free pipeline stage");

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s2_adv |=> s1_valid_reg)
        else $error("stage 1 item dropped under stall");

    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_tdata[0] |=> count_reg >= $past(count_reg))
        else $error("sample count went backward without restart");

endmodule

`default_nettype wire

[rtl/dtsg_sine_rom.sv]
// Full-cycle Q1.15 sine ROM, two synchronous read ports with shared enable.
// Depends on dtsg_pkg (quarter_sine, PI_HALF_Q30).
`default_nettype none

module dtsg_sine_rom #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                                   aclk,
    input  wire logic                                   rd_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]         rd_addr_a,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]         rd_addr_b,
    output logic signed [dtsg_pkg::SAMPLE_W-1:0]        rd_data_a_reg,
    output logic signed [dtsg_pkg::SAMPLE_W-1:0]        rd_data_b_reg
);

    function automatic logic signed [dtsg_pkg::SAMPLE_W-1:0] rom_entry(input int k);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [dtsg_pkg::SAMPLE_W-1:0] m;
        q = (64'(4 * k)) / TABLE_DEPTH;
        r = 64'(4 * k) - q * TABLE_DEPTH;
        if (q[0]) begin
            r = 64'(TABLE_DEPTH) - r;
        end
        x = (dtsg_pkg::PI_HALF_Q30 * r) / TABLE_DEPTH;
        m = dtsg_pkg::quarter_sine(x);
        return (q >= 64'd2) ? -signed'(m) : signed'(m);
    endfunction

    logic signed [dtsg_pkg::SAMPLE_W-1:0] rom_mem [TABLE_DEPTH];

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : gen_rom
        localparam logic signed [dtsg_pkg::SAMPLE_W-1:0] ENTRY = rom_entry(k);
        assign rom_mem[k] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= rom_mem[rd_addr_a];
            rd_data_b_reg <= rom_mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for dual_tone_sample_generator_top.
// Depends on dtsg_pkg and the RTL; holds its own sine table and tone predictor,
// drives bursty sample ticks with random back-pressure and checks every item.
`timescale 1ns / 100ps

module tb_top;

    localparam int TBL_BITS       = 8;
    localparam int TBL_DEPTH      = 1 << TBL_BITS;
    localparam int RAND_ITEMS     = 1450;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [dtsg_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [dtsg_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic signed [dtsg_pkg::SAMPLE_W-1:0] sample;
        logic                                 done;
    } tone_result_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic [dtsg_pkg::CFG_INDEX_W-1:0] idx;
        logic [dtsg_pkg::CFG_DATA_W-1:0]  val;
        logic                             restart;
        logic                             known;
        logic [dtsg_pkg::SAMPLE_W-1:0]    k_sample;
        logic                             k_done;
    } dir_row_t;

    localparam int DIR_ROWS = 42;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [dtsg_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [dtsg_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [0:0]                       m_tuser;
    logic                             cfg_wr_en = 1'b0;
    logic [dtsg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dtsg_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    always #2 aclk = ~aclk;

    dual_tone_sample_generator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [0] restart
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [15:0] sample
        .m_tuser   (m_tuser),   // [0] done_res
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic signed [dtsg_pkg::SAMPLE_W-1:0] sine_tbl [TBL_DEPTH];
    logic [dtsg_pkg::STEP_W-1:0]  step_a     = dtsg_pkg::RST_PHASE_STEP_A;
    logic [dtsg_pkg::STEP_W-1:0]  step_b     = dtsg_pkg::RST_PHASE_STEP_B;
    logic                         tone_mode  = dtsg_pkg::RST_TONE_MODE;
    logic [dtsg_pkg::AMP_W-1:0]   amp        = dtsg_pkg::RST_AMPLITUDE;
    logic [dtsg_pkg::COUNT_W-1:0] duration   = dtsg_pkg::RST_DURATION;
    logic [dtsg_pkg::STEP_W-1:0]  acc_a      = '0;
    logic [dtsg_pkg::STEP_W-1:0]  acc_b      = '0;
    logic [dtsg_pkg::COUNT_W-1:0] play_count = '0;

    tone_result_t samples_due [$];
    int unsigned  fail_count  = 0;
    int unsigned  idle_cycles = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b1, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b1, 1'b1, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, dtsg_pkg::REG_AMPLITUDE, 32'd32767, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, dtsg_pkg::REG_PHASE_STEP_A, 32'h4000_0000, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b1, 1'b1, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, dtsg_pkg::REG_PHASE_STEP_A, 32'h8000_0000, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b1, 1'b1, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b1, 16'd0, 1'b0},
        '{ROW_WRITE, dtsg_pkg::REG_AMPLITUDE, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b1, 16'd0, 1'b0},
        '{ROW_WRITE, dtsg_pkg::REG_AMPLITUDE, 32'd32767, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, dtsg_pkg::REG_TONE_MODE, 32'd1, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, dtsg_pkg::REG_PHASE_STEP_A, 32'h4000_0000, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, dtsg_pkg::REG_PHASE_STEP_B, 32'h4000_0000, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b1, 1'b1, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, dtsg_pkg::REG_PHASE_STEP_B, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b1, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, dtsg_pkg::REG_DURATION_SAMPLES, 32'd3, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b1, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b1, 16'd0, 1'b1},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b1, 16'd0, 1'b1},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b1, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, dtsg_pkg::REG_DURATION_SAMPLES, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, REG_UNMAPPED_LO, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, REG_UNMAPPED_HI, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        // count already past the new duration: silence at once
        '{ROW_WRITE, dtsg_pkg::REG_DURATION_SAMPLES, 32'd2, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_ITEM,  dtsg_pkg::REG_PHASE_STEP_A, 32'd0, 1'b0, 1'b1, 16'd0, 1'b1},
        '{ROW_WRITE, dtsg_pkg::REG_DURATION_SAMPLES, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, dtsg_pkg::REG_TONE_MODE, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE, dtsg_pkg::REG_AMPLITUDE, 32'd16000, 1'b0, 1'b0, 16'd0, 1'b0}
    };

    function automatic logic [dtsg_pkg::SAMPLE_W-1:0] quarter_mag(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned sum;
        longint unsigned v;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 0;
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                neg += term;
            end else begin
                pos += term;
            end
        end
        sum = (pos > neg) ? pos - neg : 0;
        if (sum > dtsg_pkg::ONE_Q30) begin
            sum = dtsg_pkg::ONE_Q30;
        end
        v = (sum * 32767 + (dtsg_pkg::ONE_Q30 >> 1)) >> 30;
        if (v > 32767) begin
            v = 32767;
        end
        return v[dtsg_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic void fill_sine_table();
        longint unsigned q;
        longint unsigned r;
        logic signed [dtsg_pkg::SAMPLE_W-1:0] m;
        for (int k = 0; k < TBL_DEPTH; k++) begin
            q = (4 * k) / TBL_DEPTH;
            r = 4 * k - q * TBL_DEPTH;
            if (q % 2 == 1) begin
                r = TBL_DEPTH - r;
            end
            m = quarter_mag((dtsg_pkg::PI_HALF_Q30 * r) / TBL_DEPTH);
            sine_tbl[k] = (q >= 2) ? -m : m;
        end
    endfunction

    function automatic void predict_tone_sample(input logic restart);
        int sa;
        int sb;
        int prod;
        tone_result_t res;
        if (restart) begin
            acc_a      = '0;
            acc_b      = '0;
            play_count = '0;
        end
        if (duration != 0 && play_count >= duration) begin
            res.sample = '0;
            res.done   = 1'b1;
        end else begin
            sa = sine_tbl[acc_a[dtsg_pkg::STEP_W-1 -: TBL_BITS]];
            sb = sine_tbl[acc_b[dtsg_pkg::STEP_W-1 -: TBL_BITS]];
            if (tone_mode) begin
                prod = (sa + sb) * int'({17'b0, amp[dtsg_pkg::AMP_W-1:1]});
            end else begin
                prod = sa * int'({17'b0, amp});
            end
            res.sample = 16'(prod / 32768);
            res.done   = 1'b0;
            acc_a += step_a;
            acc_b += step_b;
            if (play_count != '1) begin
                play_count++;
            end
        end
        samples_due.push_back(res);
    endfunction

    task automatic send_sample(input logic restart);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(dtsg_pkg::S_TDATA_W-1){1'b0}}, restart};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        predict_tone_sample(restart);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        wait (samples_due.size() == 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [dtsg_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [dtsg_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            dtsg_pkg::REG_PHASE_STEP_A:     step_a    = val;
            dtsg_pkg::REG_PHASE_STEP_B:     step_b    = val;
            dtsg_pkg::REG_TONE_MODE:        tone_mode = val[0];
            dtsg_pkg::REG_AMPLITUDE:        amp       = val[dtsg_pkg::AMP_W-1:0];
            dtsg_pkg::REG_DURATION_SAMPLES: duration  = val;
            default: ;
        endcase
    endtask

    function automatic logic [dtsg_pkg::STEP_W-1:0] pick_step();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'h8000_0000;
            2: return $urandom_range(1, 32'h0010_0000);
            default: return $urandom_range(0, 32'h8000_0000);
        endcase
    endfunction

    task automatic retune();
        logic [dtsg_pkg::CFG_DATA_W-1:0] v;
        if ($urandom_range(0, 1)) cfg_write(dtsg_pkg::REG_PHASE_STEP_A, pick_step());
        if ($urandom_range(0, 1)) cfg_write(dtsg_pkg::REG_PHASE_STEP_B, pick_step());
        if ($urandom_range(0, 1)) cfg_write(dtsg_pkg::REG_TONE_MODE, $urandom_range(0, 1));
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
                0: v = 0;
                1: v = 32767;
                default: v = $urandom_range(0, 32767);
            endcase
            cfg_write(dtsg_pkg::REG_AMPLITUDE, v);
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
                0, 1, 2: v = 0;
                3: v = 1;
                4, 5: v = $urandom_range(2, 150);
                6: v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            cfg_write(dtsg_pkg::REG_DURATION_SAMPLES, v);
        end
        if ($urandom_range(0, 5) == 0) begin
            cfg_write(logic'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)) ? REG_UNMAPPED_LO
                      : REG_UNMAPPED_HI, $urandom);
        end
    endtask

    // receiver back-pressure: the pattern is re-drawn each time rdy_cnt runs out
    int unsigned rdy_cnt  = 0;
    int unsigned rdy_mode = 0;
    always @(posedge aclk) begin
        if (rdy_cnt == 0) begin
            rdy_mode <= $urandom_range(0, 3);
            rdy_cnt  <= $urandom_range(16, 96);
        end else begin
            rdy_cnt <= rdy_cnt - 1;
        end
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rdy_cnt[1:0] != 2'd0);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge aclk) begin
        tone_result_t exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (samples_due.size() == 0) begin
                    $display("%0t: item expected none actual sample %0d done %0b", $time,
                             $signed(m_tdata[dtsg_pkg::SAMPLE_W-1:0]), m_tuser[0]);
                    fail_count++;
                end else begin
                    exp_r = samples_due.pop_front();
                    if (m_tdata[dtsg_pkg::SAMPLE_W-1:0] !== exp_r.sample) begin
                        $display("%0t: sample expected %0d actual %0d", $time,
                                 exp_r.sample, $signed(m_tdata[dtsg_pkg::SAMPLE_W-1:0]));
                        fail_count++;
                    end
                    if (m_tuser[0] !== exp_r.done) begin
                        $display("%0t: done_res expected %0b actual %0b", $time,
                                 exp_r.done, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("dual_tone_sample_generator_top: mismatch");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned  rand_sent;
        int unsigned  phase_items;
        int unsigned  burst_left;
        int unsigned  gap;
        tone_result_t known_r;
        fill_sine_table();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                wait_idle();
                cfg_write(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                send_sample(dir_rows[i].restart);
                if (dir_rows[i].known) begin
                    known_r.sample = dir_rows[i].k_sample;
                    known_r.done   = dir_rows[i].k_done;
                    samples_due[samples_due.size()-1] = known_r;
                end
            end
        end

        rand_sent  = 0;
        burst_left = 0;
        while (rand_sent < RAND_ITEMS) begin
            wait_idle();
            retune();
            phase_items = $urandom_range(40, 160);
            for (int n = 0; n < phase_items; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 15))
                        0: begin
                            s_tvalid <= 1'b0;
                            wait (samples_due.size() == 0);
                            @(posedge aclk);
                        end
                        1, 2, 3, 4, 5: ;
                        default: begin
                            gap = $urandom_range(1, 6);
                            s_tvalid <= 1'b0;
                            repeat (gap) @(posedge aclk);
                        end
                    endcase
                end
                burst_left--;
                send_sample((n == 0 && $urandom_range(0, 1)) || $urandom_range(0, 31) == 0);
                rand_sent++;
            end
        end

        s_tvalid <= 1'b0;
        wait (samples_due.size() == 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("dual_tone_sample_generator_top: match");
        end else begin
            $display("dual_tone_sample_generator_top: mismatch");
        end
        $finish;
    end

endmodule
